>>> rtl/ttw_pkg.sv
package ttw_pkg;

	localparam int COLUMNS = 80;
	localparam int ROWS    = 40;
	localparam int CELLS   = COLUMNS * ROWS;

	localparam int ADDR_W = 12;
	localparam int COL_W  = 7;
	localparam int ROW_W  = 6;
	localparam int FUNC_W = 2;
	localparam int BYTE_W = 8;

	localparam logic [FUNC_W-1:0] FN_TERM  = 2'd0;
	localparam logic [FUNC_W-1:0] FN_WRITE = 2'd1;
	localparam logic [FUNC_W-1:0] FN_READ  = 2'd2;

	localparam logic [BYTE_W-1:0] CH_LF    = 8'd10;
	localparam logic [BYTE_W-1:0] CH_CR    = 8'd13;
	localparam logic [BYTE_W-1:0] CH_BS    = 8'd8;
	localparam logic [BYTE_W-1:0] CH_DEL   = 8'd127;
	localparam logic [BYTE_W-1:0] CH_SPACE = 8'h20;

	typedef enum logic [2:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_EXEC,
		ST_COPY,
		ST_FILL,
		ST_DONE
	} state_t;

endpackage

>>> rtl/ttw_in_if.sv
interface ttw_in_if
	import ttw_pkg::*;
();
	logic              valid;
	logic              ready;
	logic [FUNC_W-1:0] func;
	logic [ADDR_W-1:0] cell_address;
	logic [BYTE_W-1:0] byte_value;

	modport source (output valid, func, cell_address, byte_value, input ready);
	modport sink   (input valid, func, cell_address, byte_value, output ready);
endinterface

>>> rtl/ttw_out_if.sv
interface ttw_out_if
	import ttw_pkg::*;
();
	logic              valid;
	logic              ready;
	logic [BYTE_W-1:0] read_data;
	logic [COL_W-1:0]  cursor_col;
	logic [ROW_W-1:0]  cursor_row;

	modport source (output valid, read_data, cursor_col, cursor_row, input ready);
	modport sink   (input valid, read_data, cursor_col, cursor_row, output ready);
endinterface

>>> rtl/text_terminal_writer.sv
// channel | dir | payload                              | handshake
// --------+-----+--------------------------------------+-------------
// req     | in  | func, cell_address, byte_value       | valid/ready
// rsp     | out | read_data, cursor_col, cursor_row    | valid/ready
//
// a word without scroll passes through accept, execute and load of the result register
// a scroll adds a copy pass that shifts every row up and a fill pass over the bottom row,
// bound by the single read and single write port of the screen store
// after reset a clearing pass writes spaces into all CELLS (3200) cells, req not ready
// a stalled rsp holds its word; the next req word is taken meanwhile and waits
// in the done state until the result register is free
module text_terminal_writer
	import ttw_pkg::*;
(
	input  logic clk,
	input  logic arst_n,
	ttw_in_if.sink    req,
	ttw_out_if.source rsp
);

	localparam logic [ADDR_W-1:0] COPY_LAST = ADDR_W'(CELLS - COLUMNS);
	localparam logic [ADDR_W-1:0] CELL_LAST = ADDR_W'(CELLS - 1);

	// sequencer state
	state_t state_q, state_d;
	logic [ADDR_W-1:0] cnt_q;

	// cursor, with the row start address kept alongside so no multiply is needed
	logic [COL_W-1:0]  col_q;
	logic [ROW_W-1:0]  row_q;
	logic [ADDR_W-1:0] base_q;

	// captured request word
	logic [FUNC_W-1:0] func_q;
	logic [ADDR_W-1:0] addr_q;
	logic [BYTE_W-1:0] val_q;
	logic              rd_en_q;

	// result register
	logic              out_valid_q;
	logic [BYTE_W-1:0] read_data_q;
	logic [COL_W-1:0]  cursor_col_q;
	logic [ROW_W-1:0]  cursor_row_q;

	// screen store, one write and one registered read port
	logic [BYTE_W-1:0] mem [CELLS];
	logic [BYTE_W-1:0] rdata_q;
	logic              we_c, re_c;
	logic [ADDR_W-1:0] wa_c, ra_c;
	logic [BYTE_W-1:0] wd_c;

	// copy pipeline: the read issued now is written in the next cycle
	logic              wvalid_s1;
	logic [ADDR_W-1:0] wa_s1;

	// decode of the captured word
	logic              is_term, is_lf, is_cr, is_bs, is_print;
	logic              addr_ok, last_col, last_row, adv_row;
	logic [COL_W-1:0]  col_dec, col_nxt;
	logic [ADDR_W-1:0] cur_idx;
	logic              out_load;

	always_comb begin
		is_term  = (func_q == FN_TERM);
		is_lf    = (val_q == CH_LF);
		is_cr    = (val_q == CH_CR);
		is_bs    = (val_q inside {CH_BS, CH_DEL});
		is_print = !is_lf && !is_cr && !is_bs;
		addr_ok  = (addr_q < ADDR_W'(CELLS));
		last_col = (col_q == COL_W'(COLUMNS - 1));
		last_row = (row_q == ROW_W'(ROWS - 1));
		adv_row  = is_lf || (is_print && last_col);
		col_dec  = (col_q != '0) ? col_q - 1'b1 : col_q;
		// backspace blanks the cell it steps onto, a printable byte lands under the cursor
		cur_idx  = base_q + ADDR_W'(is_bs ? col_dec : col_q);
		if (is_cr) begin
			col_nxt = '0;
		end else if (is_bs) begin
			col_nxt = col_dec;
		end else if (is_print) begin
			col_nxt = last_col ? '0 : col_q + 1'b1;
		end else begin
			col_nxt = col_q;
		end
	end

	assign out_load = (state_q == ST_DONE) && (!out_valid_q || rsp.ready);

	// next state and store port control
	always_comb begin
		state_d = state_q;
		we_c    = 1'b0;
		wa_c    = cnt_q;
		wd_c    = CH_SPACE;
		re_c    = 1'b0;
		ra_c    = addr_q;
		case (state_q)
			ST_CLEAR, ST_FILL: begin
				// space sweep: whole store after reset, bottom row after a scroll
				we_c = 1'b1;
				if (cnt_q == CELL_LAST) begin
					state_d = (state_q == ST_CLEAR) ? ST_IDLE : ST_DONE;
				end
			end
			ST_IDLE: begin
				if (req.valid) begin
					state_d = ST_EXEC;
				end
			end
			ST_EXEC: begin
				state_d = ST_DONE;
				case (func_q)
					FN_TERM: begin
						if (is_bs || is_print) begin
							we_c = 1'b1;
							wa_c = cur_idx;
							wd_c = is_bs ? CH_SPACE : val_q;
						end
						if (adv_row && last_row) begin
							state_d = ST_COPY;
						end
					end
					FN_WRITE: begin
						we_c = addr_ok;
						wa_c = addr_q;
						wd_c = val_q;
					end
					FN_READ: begin
						re_c = addr_ok;
						ra_c = addr_q;
					end
					default: begin
						// unused code: result only
					end
				endcase
			end
			ST_COPY: begin
				// shift every row up by one, read one row ahead of the write
				if (cnt_q != COPY_LAST) begin
					re_c = 1'b1;
					ra_c = cnt_q + ADDR_W'(COLUMNS);
				end else begin
					state_d = ST_FILL;
				end
				if (wvalid_s1) begin
					we_c = 1'b1;
					wa_c = wa_s1;
					wd_c = rdata_q;
				end
			end
			ST_DONE: begin
				if (out_load) begin
					state_d = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	assign req.ready = (state_q == ST_IDLE);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_CLEAR;
			cnt_q       <= '0;
			col_q       <= '0;
			row_q       <= '0;
			base_q      <= '0;
			out_valid_q <= 1'b0;
			wvalid_s1   <= 1'b0;
		end else begin
			state_q   <= state_d;
			wvalid_s1 <= (state_q == ST_COPY) && re_c;
			case (state_q)
				ST_CLEAR, ST_FILL: begin
					if (cnt_q != CELL_LAST) begin
						cnt_q <= cnt_q + 1'b1;
					end
				end
				ST_EXEC: begin
					cnt_q <= '0;
					if (is_term) begin
						col_q <= col_nxt;
						// on the last row the row stays and the store scrolls
						if (adv_row && !last_row) begin
							row_q  <= row_q + 1'b1;
							base_q <= base_q + ADDR_W'(COLUMNS);
						end
					end
				end
				ST_COPY: begin
					if (cnt_q != COPY_LAST) begin
						cnt_q <= cnt_q + 1'b1;
					end
				end
				default: begin
				end
			endcase
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (rsp.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		wa_s1 <= cnt_q;
		if (req.valid && req.ready) begin
			func_q <= req.func;
			addr_q <= req.cell_address;
			val_q  <= req.byte_value;
		end
		if (state_q == ST_EXEC) begin
			rd_en_q <= (func_q == FN_READ) && addr_ok;
		end
		if (out_load) begin
			read_data_q  <= rd_en_q ? rdata_q : '0;
			cursor_col_q <= col_q;
			cursor_row_q <= row_q;
		end
	end

	// screen store
	always_ff @(posedge clk) begin
		if (we_c) begin
			mem[wa_c] <= wd_c;
		end
		if (re_c) begin
			rdata_q <= mem[ra_c];
		end
	end

	assign rsp.valid      = out_valid_q;
	assign rsp.read_data  = read_data_q;
	assign rsp.cursor_col = cursor_col_q;
	assign rsp.cursor_row = cursor_row_q;

	a_cursor_range: assert property (@(posedge clk) disable iff (!arst_n)
		(col_q < COL_W'(COLUMNS)) && (row_q < ROW_W'(ROWS)))
		else $error("cursor out of screen");

	a_base_match: assert property (@(posedge clk) disable iff (!arst_n)
		base_q == ADDR_W'(ADDR_W'(row_q) * ADDR_W'(COLUMNS)))
		else $error("row start address out of step with cursor row");

	a_copy_no_clash: assert property (@(posedge clk) disable iff (!arst_n)
		(we_c && re_c) |-> (wa_c != ra_c))
		else $error("store read and write collide");

	a_accept_exec: assert property (@(posedge clk) disable iff (!arst_n)
		(req.valid && req.ready) |=> (state_q == ST_EXEC))
		else $error("accepted word not executed");

	a_scroll_fill: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_COPY && state_d == ST_FILL) |=> (cnt_q == COPY_LAST))
		else $error("bottom row fill starts at wrong cell");

endmodule

>>> tb/tb.sv
module tb;
	import ttw_pkg::*;

	// func code 3 is not used by the block: the word must change nothing
	localparam logic [FUNC_W-1:0] FN_NONE = 2'd3;

	// longest quiet stretch: the clearing pass after reset or one scroll,
	// plus receiver stalls, with a wide margin
	localparam int STALL_LIMIT  = 20000;
	localparam int TAIL_CYCLES  = 40;
	localparam int RANDOM_WORDS = 450;

	typedef struct packed {
		logic [FUNC_W-1:0] func;
		logic [ADDR_W-1:0] addr;
		logic [BYTE_W-1:0] value;
	} term_word_t;

	typedef struct packed {
		logic [BYTE_W-1:0] data;
		logic [COL_W-1:0]  col;
		logic [ROW_W-1:0]  row;
	} cursor_report_t;

	logic clk = 1'b0;
	logic arst_n;

	ttw_in_if  req_ch ();
	ttw_out_if rsp_ch ();

	text_terminal_writer dut (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req_ch),
		.rsp    (rsp_ch)
	);

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	// words waiting to be sent, and reports the screen model says must come back
	term_word_t     pending_words[$];
	cursor_report_t expected_reports[$];

	// screen model: the store, row after row, and the cursor
	logic [BYTE_W-1:0] screen_shadow [CELLS];
	logic [COL_W-1:0]  shadow_col;
	logic [ROW_W-1:0]  shadow_row;

	int total_words;
	int words_taken;
	int reports_checked;
	int error_count;
	int scroll_count;
	int wrap_count;
	int read_count;
	int quiet_cycles;

	// cursor moves down one row; from the last row shift the store up one row, blank the bottom
	function automatic void cursor_down();
		if (int'(shadow_row) + 1 >= ROWS) begin
			for (int i = 0; i < CELLS - COLUMNS; i++)
				screen_shadow[i] = screen_shadow[i + COLUMNS];
			for (int i = CELLS - COLUMNS; i < CELLS; i++)
				screen_shadow[i] = CH_SPACE;
			scroll_count++;
		end else begin
			shadow_row = shadow_row + 1'b1;
		end
	endfunction

	// apply one word to the screen model and return the report it causes
	function automatic cursor_report_t screen_step(term_word_t w);
		cursor_report_t r;
		int at;
		r = '0;
		case (w.func)
			FN_TERM: begin
				if (w.value == CH_LF) begin
					cursor_down();
				end else if (w.value == CH_CR) begin
					shadow_col = '0;
				end else if (w.value == CH_BS || w.value == CH_DEL) begin
					// at column 0 the cursor stays, the cell is still blanked
					if (shadow_col != '0)
						shadow_col = shadow_col - 1'b1;
					at = int'(shadow_row) * COLUMNS + int'(shadow_col);
					screen_shadow[at] = CH_SPACE;
				end else begin
					at = int'(shadow_row) * COLUMNS + int'(shadow_col);
					screen_shadow[at] = w.value;
					if (int'(shadow_col) + 1 >= COLUMNS) begin
						shadow_col = '0;
						wrap_count++;
						cursor_down();
					end else begin
						shadow_col = shadow_col + 1'b1;
					end
				end
			end
			FN_WRITE: begin
				// addresses past the store are dropped
				if (int'(w.addr) < CELLS)
					screen_shadow[w.addr] = w.value;
			end
			FN_READ: begin
				read_count++;
				if (int'(w.addr) < CELLS)
					r.data = screen_shadow[w.addr];
			end
			default: begin
			end
		endcase
		r.col = shadow_col;
		r.row = shadow_row;
		return r;
	endfunction

	function automatic void queue_word(logic [FUNC_W-1:0] f, int a, int v);
		term_word_t w;
		w.func  = f;
		w.addr  = a[ADDR_W-1:0];
		w.value = v[BYTE_W-1:0];
		pending_words.push_back(w);
	endfunction

	// reads lean on the bottom rows, where scrolls and fresh text show up
	function automatic int pick_read_address();
		int pick;
		pick = $urandom_range(99);
		if (pick < 50)
			return $urandom_range(CELLS - 1, CELLS - 5 * COLUMNS);
		else if (pick < 85)
			return $urandom_range(CELLS - 1);
		return $urandom_range((1 << ADDR_W) - 1);
	endfunction

	// idle share in percent: receiver slow first, then sender slow, then none
	function automatic int idle_pct(bit sender);
		if (words_taken < total_words / 3)
			return sender ? 19 : 57;
		else if (words_taken < 2 * total_words / 3)
			return sender ? 57 : 19;
		return 0;
	endfunction

	// driver: present the next word once the previous one is taken
	always @(posedge clk or negedge arst_n) begin : send_words
		term_word_t w;
		term_word_t sent;
		if (!arst_n) begin
			req_ch.valid        <= 1'b0;
			req_ch.func         <= FN_TERM;
			req_ch.cell_address <= '0;
			req_ch.byte_value   <= '0;
			// screen model starts from the reset contents
			foreach (screen_shadow[i])
				screen_shadow[i] = CH_SPACE;
			shadow_col = '0;
			shadow_row = '0;
		end else begin
			if (req_ch.valid && req_ch.ready) begin
				// word accepted: run it through the screen model now
				sent.func  = req_ch.func;
				sent.addr  = req_ch.cell_address;
				sent.value = req_ch.byte_value;
				expected_reports.push_back(screen_step(sent));
				words_taken++;
			end
			if (!req_ch.valid || req_ch.ready) begin
				if (pending_words.size() != 0 && $urandom_range(99) >= idle_pct(1'b1)) begin
					w = pending_words.pop_front();
					req_ch.valid        <= 1'b1;
					req_ch.func         <= w.func;
					req_ch.cell_address <= w.addr;
					req_ch.byte_value   <= w.value;
				end else begin
					req_ch.valid <= 1'b0;
				end
			end
		end
	end

	// monitor: every report is checked against the oldest prediction
	always @(posedge clk or negedge arst_n) begin : check_reports
		cursor_report_t seen;
		cursor_report_t want;
		if (!arst_n) begin
			rsp_ch.ready <= 1'b0;
		end else begin
			rsp_ch.ready <= ($urandom_range(99) >= idle_pct(1'b0));
			if (rsp_ch.valid && rsp_ch.ready) begin
				seen.data = rsp_ch.read_data;
				seen.col  = rsp_ch.cursor_col;
				seen.row  = rsp_ch.cursor_row;
				if (expected_reports.size() == 0) begin
					$display("%0t: unexpected report, expected none, got data %02h col %0d row %0d",
						$time, seen.data, seen.col, seen.row);
					error_count++;
				end else begin
					want = expected_reports.pop_front();
					reports_checked++;
					if (seen !== want) begin
						$display("%0t: report mismatch, expected data %02h col %0d row %0d, got data %02h col %0d row %0d",
							$time, want.data, want.col, want.row,
							seen.data, seen.col, seen.row);
						error_count++;
					end
				end
			end
		end
	end

	// watchdog: too long without a word moving on either side
	always @(posedge clk) begin
		if (arst_n) begin
			if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready))
				quiet_cycles <= 0;
			else if (quiet_cycles + 1 >= STALL_LIMIT) begin
				$display("%0t: no word moved for %0d cycles", $time, STALL_LIMIT);
				$display("tb: done, errors");
				$finish;
			end else begin
				quiet_cycles <= quiet_cycles + 1;
			end
		end
	end

	initial begin
		int random_words;
		int kind;
		int len;
		int a;
		int b;

		// reset held low from time zero
		arst_n = 1'b0;

		// directed: reset contents, address extremes, out-of-range access
		queue_word(FN_READ, 0, 0);
		queue_word(FN_READ, CELLS - 1, 8'hFF);
		queue_word(FN_READ, CELLS, 0);
		queue_word(FN_READ, (1 << ADDR_W) - 1, 0);
		// backspace and delete at column 0
		queue_word(FN_TERM, 0, CH_BS);
		queue_word(FN_TERM, 0, CH_DEL);
		// byte value extremes stored as text
		queue_word(FN_TERM, (1 << ADDR_W) - 1, 8'h00);
		queue_word(FN_TERM, 0, 8'hFF);
		queue_word(FN_TERM, 0, "A");
		queue_word(FN_TERM, 0, CH_DEL);
		queue_word(FN_TERM, 0, CH_BS);
		queue_word(FN_READ, 0, 0);
		queue_word(FN_READ, 2, 0);
		queue_word(FN_TERM, 0, CH_CR);
		// direct writes at both ends and past the store
		queue_word(FN_WRITE, 0, 8'hFF);
		queue_word(FN_WRITE, CELLS - 1, 8'h00);
		queue_word(FN_WRITE, CELLS, 8'h55);
		queue_word(FN_WRITE, (1 << ADDR_W) - 1, 8'hAA);
		queue_word(FN_READ, 0, 0);
		queue_word(FN_READ, CELLS - 1, 0);
		// unused func code with every bit set
		queue_word(FN_NONE, (1 << ADDR_W) - 1, 8'hFF);
		queue_word(FN_TERM, 0, CH_LF);
		queue_word(FN_READ, COLUMNS, 0);

		// random: bursts shaped like console traffic, lines and line feeds
		// carry the cursor down to the last row so scrolls keep happening
		random_words = 0;
		while (random_words < RANDOM_WORDS) begin
			kind = $urandom_range(99);
			if (kind < 35) begin
				// a line of text, now and then long enough to wrap
				len = ($urandom_range(19) == 0) ? $urandom_range(100, 60) : $urandom_range(12, 1);
				for (int i = 0; i < len; i++) begin
					b = ($urandom_range(7) == 0) ? $urandom_range(255) : $urandom_range(126, 32);
					queue_word(FN_TERM, $urandom_range((1 << ADDR_W) - 1), b);
				end
				random_words += len;
				if ($urandom_range(4) != 0) begin
					queue_word(FN_TERM, $urandom_range((1 << ADDR_W) - 1), CH_CR);
					queue_word(FN_TERM, $urandom_range((1 << ADDR_W) - 1), CH_LF);
					random_words += 2;
				end
			end else if (kind < 55) begin
				len = $urandom_range(6, 1);
				for (int i = 0; i < len; i++)
					queue_word(FN_TERM, $urandom_range((1 << ADDR_W) - 1), CH_LF);
				random_words += len;
			end else if (kind < 63) begin
				len = $urandom_range(4, 1);
				for (int i = 0; i < len; i++)
					queue_word(FN_TERM, $urandom_range((1 << ADDR_W) - 1),
						$urandom_range(1) ? CH_BS : CH_DEL);
				random_words += len;
			end else if (kind < 76) begin
				// direct write, often read back at once
				a = ($urandom_range(4) == 0) ? $urandom_range((1 << ADDR_W) - 1)
					: $urandom_range(CELLS - 1);
				queue_word(FN_WRITE, a, $urandom_range(255));
				random_words++;
				if ($urandom_range(1)) begin
					queue_word(FN_READ, a, $urandom_range(255));
					random_words++;
				end
			end else if (kind < 92) begin
				len = $urandom_range(3, 1);
				for (int i = 0; i < len; i++)
					queue_word(FN_READ, pick_read_address(), $urandom_range(255));
				random_words += len;
			end else begin
				// noise: unused func code or any byte at all
				queue_word($urandom_range(1) ? FN_NONE : FN_TERM,
					$urandom_range((1 << ADDR_W) - 1), $urandom_range(255));
				random_words++;
			end
		end
		total_words = pending_words.size();

		repeat (5) @(posedge clk);
		arst_n <= 1'b1;

		// everything sent and every report back, then a quiet tail
		do
			@(posedge clk);
		while (pending_words.size() != 0 || req_ch.valid || expected_reports.size() != 0);
		repeat (TAIL_CYCLES) @(posedge clk);

		$display("tb: %0d words sent, %0d reports checked, %0d cell reads",
			words_taken, reports_checked, read_count);
		$display("tb: %0d scrolls, %0d line wraps, %0d mismatches",
			scroll_count, wrap_count, error_count);
		if (error_count == 0)
			$display("tb: done, clean");
		else
			$display("tb: done, errors");
		$finish;
	end

endmodule
